// ----- rtl/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// LZSS word decoder package
// Shared types for the controller and the datapath of the decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   // Width of one compressed code word.
   localparam int WORD_BITS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_COPY_RD,
      ST_COPY_EMIT,
      ST_FLUSH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_LIT,
      PH_OFF,
      PH_LEN
   } phase_type;

   typedef struct packed {
      logic load_word;
      logic step_bit;
      logic end_word;
      logic copy_read;
      logic copy_emit;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic bit_done;
      logic comp_lit;
      logic comp_len;
      logic copy_last;
      logic hold_valid;
      logic out_free;
      logic emit_ok;
   } dp_sts_type;

endpackage

// ----- rtl/lzwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// LZSS word decoder controller
// Sequences bit decoding, window copies and the end-of-word flush.
// ----------------------------------------------------------------------------
module lzwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lzwd_pkg::dp_sts_type   sts,
   output lzwd_pkg::dp_cmd_type   cmd
);
   import lzwd_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (sts.bit_done) begin
               state_in = ST_FLUSH;
            end else if (sts.comp_len) begin
               state_in = ST_COPY_RD;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_EMIT;
         end
         ST_COPY_EMIT: begin
            if (sts.emit_ok) begin
               state_in = sts.copy_last ? ST_BIT : ST_COPY_RD;
            end
         end
         ST_FLUSH: begin
            if (!sts.hold_valid || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_word = req_tvalid;
         end
         ST_BIT: begin
            if (sts.bit_done) begin
               cmd.end_word = 1'b1;
            end else if (!sts.comp_lit || sts.emit_ok) begin
               cmd.step_bit = 1'b1;
            end
         end
         ST_COPY_RD: begin
            cmd.copy_read = 1'b1;
         end
         ST_COPY_EMIT: begin
            cmd.copy_emit = sts.emit_ok;
         end
         ST_FLUSH: begin
            cmd.flush = sts.hold_valid && sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/lzwd_datapath.sv -----
// ----------------------------------------------------------------------------
// LZSS word decoder datapath
// Bit shifter, token fields, history window, hold stage and output register.
// ----------------------------------------------------------------------------
module lzwd_datapath #(
   parameter int OFFSET_BITS = 11,
   parameter int LENGTH_BITS = 4,
   parameter int SYMBOL_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               code_word,
   input  logic                      final_word,
   input  lzwd_pkg::dp_cmd_type      cmd,
   output lzwd_pkg::dp_sts_type      sts,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [SYMBOL_BITS-1:0]    rsp_symbol,
   output logic                      rsp_tlast
);
   import lzwd_pkg::*;

   localparam int WIN_SIZE  = 1 << OFFSET_BITS;
   localparam int ACC_BITS  = (SYMBOL_BITS > OFFSET_BITS) ? SYMBOL_BITS : OFFSET_BITS;
   localparam int PEND_BITS = $clog2(ACC_BITS + 1);
   localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
   localparam int K_BITS    = LENGTH_BITS + 1;
   localparam int FILL_BITS = OFFSET_BITS + 1;
   localparam logic [OFFSET_BITS-1:0] RESET_WP =
      OFFSET_BITS'(WIN_SIZE - (1 << LENGTH_BITS) - 1);
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WIN_SIZE);

   // Bit shifter and word bookkeeping.
   logic [WORD_BITS-1:0]   word_ff;
   logic [CNT_BITS-1:0]    bitcnt_ff;
   logic                   final_ff;

   // Token state.
   phase_type              phase_ff;
   logic [PEND_BITS-1:0]   pend_ff;
   logic [ACC_BITS-1:0]    acc_ff;
   logic [OFFSET_BITS-1:0] moff_ff;
   logic [K_BITS-1:0]      klast_ff;
   logic [K_BITS-1:0]      k_ff;

   // Window state.
   logic [SYMBOL_BITS-1:0] win_mem [WIN_SIZE];
   logic [OFFSET_BITS-1:0] wp_ff;
   logic [FILL_BITS-1:0]   fill_ff;
   logic [SYMBOL_BITS-1:0] rd_data_ff;
   logic                   rd_written_ff;

   // Hold stage and output register.
   logic                   hold_valid_ff;
   logic [SYMBOL_BITS-1:0] hold_sym_ff;
   logic                   out_valid_ff;
   logic [SYMBOL_BITS-1:0] out_sym_ff;
   logic                   out_last_ff;

   logic                   cur_bit;
   logic [ACC_BITS-1:0]    acc_next;
   logic [PEND_BITS-1:0]   pend_next;
   logic [PEND_BITS-1:0]   need;
   logic                   complete;
   logic                   comp_lit;
   logic                   comp_off;
   logic                   comp_len;
   logic                   emit;
   logic [SYMBOL_BITS-1:0] emit_sym;
   logic                   push;
   logic                   out_free;
   logic [OFFSET_BITS-1:0] rd_addr;
   logic [OFFSET_BITS-1:0] rd_rel;

   assign cur_bit   = word_ff[WORD_BITS-1];
   assign acc_next  = {acc_ff[ACC_BITS-2:0], cur_bit};
   assign pend_next = pend_ff + 1'b1;

   always_comb begin
      case (phase_ff)
         PH_LIT:  need = PEND_BITS'(SYMBOL_BITS);
         PH_OFF:  need = PEND_BITS'(OFFSET_BITS);
         PH_LEN:  need = PEND_BITS'(LENGTH_BITS);
         default: need = '0;
      endcase
   end

   assign complete = (phase_ff != PH_FLAG) && (pend_next == need);
   assign comp_lit = complete && (phase_ff == PH_LIT);
   assign comp_off = complete && (phase_ff == PH_OFF);
   assign comp_len = complete && (phase_ff == PH_LEN);

   // Entries never written since reset read as zero: writes advance one
   // address at a time from the reset position, so the fill count tells.
   assign rd_addr  = moff_ff + OFFSET_BITS'(k_ff);
   assign rd_rel   = rd_addr - RESET_WP;

   assign emit     = (cmd.step_bit && comp_lit) || cmd.copy_emit;
   assign emit_sym = cmd.copy_emit ? (rd_written_ff ? rd_data_ff : '0)
                                   : acc_next[SYMBOL_BITS-1:0];
   assign out_free = !out_valid_ff || rsp_tready;
   assign push     = (emit && hold_valid_ff) || cmd.flush;

   always_ff @(posedge clock) begin
      if (emit) begin
         win_mem[wp_ff] <= emit_sym;
      end
      if (cmd.copy_read) begin
         rd_data_ff    <= win_mem[rd_addr];
         rd_written_ff <= {1'b0, rd_rel} < fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitcnt_ff     <= '0;
         final_ff      <= 1'b0;
         phase_ff      <= PH_FLAG;
         pend_ff       <= '0;
         acc_ff        <= '0;
         moff_ff       <= '0;
         k_ff          <= '0;
         klast_ff      <= '0;
         wp_ff         <= RESET_WP;
         fill_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load_word) begin
            bitcnt_ff <= '0;
            final_ff  <= final_word;
         end
         if (cmd.step_bit) begin
            bitcnt_ff <= bitcnt_ff + 1'b1;
            if (phase_ff == PH_FLAG) begin
               phase_ff <= cur_bit ? PH_LIT : PH_OFF;
               pend_ff  <= '0;
               acc_ff   <= '0;
            end else if (!complete) begin
               pend_ff <= pend_next;
               acc_ff  <= acc_next;
            end else begin
               pend_ff <= '0;
               acc_ff  <= '0;
               if (comp_off) begin
                  moff_ff  <= acc_next[OFFSET_BITS-1:0];
                  phase_ff <= PH_LEN;
               end else begin
                  phase_ff <= PH_FLAG;
               end
               if (comp_len) begin
                  k_ff     <= '0;
                  klast_ff <= K_BITS'(acc_next[LENGTH_BITS-1:0]) + 1'b1;
               end
            end
         end
         if (cmd.copy_emit) begin
            k_ff <= k_ff + 1'b1;
         end
         // A final word drops whatever partial token it leaves behind.
         if (cmd.end_word && final_ff) begin
            phase_ff <= PH_FLAG;
            pend_ff  <= '0;
            acc_ff   <= '0;
         end
         if (emit) begin
            wp_ff <= wp_ff + 1'b1;
            if (fill_ff != FILL_FULL) begin
               fill_ff <= fill_ff + 1'b1;
            end
            hold_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // The newest symbol waits in the hold stage until the next one or the end
   // of the word shows whether it is the last of the word.
   always_ff @(posedge clock) begin
      if (emit) begin
         hold_sym_ff <= emit_sym;
      end
      if (push) begin
         out_sym_ff  <= hold_sym_ff;
         out_last_ff <= cmd.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         word_ff <= code_word;
      end else if (cmd.step_bit) begin
         word_ff <= {word_ff[WORD_BITS-2:0], 1'b0};
      end
   end

   assign sts.bit_done   = bitcnt_ff == CNT_BITS'(WORD_BITS);
   assign sts.comp_lit   = comp_lit;
   assign sts.comp_len   = comp_len;
   assign sts.copy_last  = k_ff == klast_ff;
   assign sts.hold_valid = hold_valid_ff;
   assign sts.out_free   = out_free;
   assign sts.emit_ok    = !hold_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_symbol = out_sym_ff;
   assign rsp_tlast  = out_last_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("window fill count beyond window size");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("symbol pushed into a full output register");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      !(cmd.step_bit && (cmd.copy_emit || cmd.copy_read || cmd.flush)))
      else $error("bit step overlaps a copy or flush");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !hold_valid_ff)
      else $error("hold stage still full after flush");

endmodule

// ----- rtl/lzwd_ctrl_check_order.sv -----
// ----------------------------------------------------------------------------
// LZSS word decoder port checker
// Watches the top-level ports for handshake and word-boundary rules.
// ----------------------------------------------------------------------------
module lzwd_ctrl_check_order (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);

   // A new word is only taken once every symbol of the previous one has
   // left the hold stage, so a transfer in is never followed by another.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("two words taken in consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tlast)))
      else $error("stalled result changed");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(req_tready) |-> !$past(req_tvalid && req_tready))
      else $error("ready rose straight after a word transfer");

endmodule

// ----- rtl/lzss_word_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// LZSS word decoder
// Decodes an LZSS bitstream of 16-bit code words into 16-bit symbols.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one code word per transfer, read MSB first as one
//   continuous bitstream; req_tlast marks the final word of a stream, after
//   which any partial token is dropped.
//   rsp_ channel carries the decoded symbols; rsp_tlast is set on the last
//   symbol produced by a code word. A word that completes no token gives none.
// Timing:
//   A word is taken in the idle state, and its 16 bits are decoded one per
//   cycle while no copy runs and the output can take each new symbol; the
//   word is then closed and its last symbol handed over. Each symbol of a
//   window copy takes a window read, then a write and output. req_tready is
//   high only between words.
// Reset:
//   The window reads as zero until written; this is tracked by a fill count,
//   so the block is ready in the first cycle after reset.
// Stalls:
//   When rsp_tready is low, decoding halts at the next symbol and resumes
//   once the output register drains; nothing is lost.
// ----------------------------------------------------------------------------
module lzss_word_decoder_unit #(
   parameter int OFFSET_BITS = 11,
   parameter int LENGTH_BITS = 4,
   parameter int SYMBOL_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,  // code_word
   input  logic                                   req_tlast,  // final_word
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SYMBOL_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // symbol_out
   output logic                                   rsp_tlast   // last_of_run
);
   import lzwd_pkg::*;

   localparam int TDATA_BITS = ((SYMBOL_BITS + 7) / 8) * 8;

   dp_cmd_type             cmd;
   dp_sts_type             sts;
   logic [SYMBOL_BITS-1:0] rsp_symbol;

   lzwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lzwd_datapath #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .code_word  (req_tdata),
      .final_word (req_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_symbol (rsp_symbol),
      .rsp_tlast  (rsp_tlast)
   );

   lzwd_ctrl_check_order u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = TDATA_BITS'(rsp_symbol);

endmodule

// ----- bench/lzss_word_decoder_unit_test.sv -----
// ----------------------------------------------------------------------------
// LZSS word decoder regression
// Feeds code words into the decoder and compares every decoded symbol with a
// behavioural copy of the decoder that runs when each code word is accepted.
// Directed streams come first: extreme literals, overlapping and wrapping
// window copies, and dropped partial tokens. Random streams and noise words
// follow under several idling mixes, and a long output hold-off ends the run.
// ----------------------------------------------------------------------------
module lzss_word_decoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lzwd_pkg::*;

   localparam int OFF_BITS  = 11;
   localparam int LEN_BITS  = 4;
   localparam int SYM_BITS  = 16;
   localparam int WIN_DEPTH = 1 << OFF_BITS;
   localparam int START_POS = WIN_DEPTH - ((1 << LEN_BITS) + 1);

   typedef struct packed {
      logic [SYM_BITS-1:0] symbol;
      logic                last_of_run;
   } decoded_symbol_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [WORD_BITS-1:0] req_tdata;   // code_word
   logic                 req_tlast;   // final_word
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [SYM_BITS-1:0]  rsp_tdata;   // symbol_out
   logic                 rsp_tlast;   // last_of_run

   // Expected symbols, oldest first, and the symbols of the word being decoded.
   decoded_symbol_type pending_symbols[$];
   logic [SYM_BITS-1:0] word_symbols[$];

   // Behavioural copy of the decoder state.
   logic [SYM_BITS-1:0] window_copy [WIN_DEPTH];
   logic [OFF_BITS-1:0] window_wpos;
   phase_type           token_phase_m;
   int                  token_bits;
   logic [15:0]         token_acc;
   logic [OFF_BITS-1:0] copy_offset;

   // Bitstream under construction and the write position it will have reached.
   bit                  stream_bits[$];
   logic [OFF_BITS-1:0] plan_pos;

   int mismatch_count;
   int words_sent;
   int symbols_checked;
   int literal_tokens;
   int copy_tokens;
   int send_idle_pct;
   int stall_pct;
   int hold_request;
   int hold_left;

   lzss_word_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The receiver either stalls at random or, on request, holds off for a
   // long counted stretch.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t: mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      decoded_symbol_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_symbols.size() == 0) begin
            report_mismatch($sformatf("symbol %h arrived with none expected", rsp_tdata));
         end else begin
            want = pending_symbols.pop_front();
            symbols_checked++;
            if (rsp_tdata !== want.symbol)
               report_mismatch($sformatf("symbol %0d: got %h, expected %h",
                                         symbols_checked, rsp_tdata, want.symbol));
            if (rsp_tlast !== want.last_of_run)
               report_mismatch($sformatf("symbol %0d: tlast %b, expected %b",
                                         symbols_checked, rsp_tlast, want.last_of_run));
         end
      end
   end

   function automatic void clear_decoder_copy();
      for (int i = 0; i < WIN_DEPTH; i++)
         window_copy[i] = '0;
      window_wpos = OFF_BITS'(START_POS);
      token_phase_m = PH_FLAG;
      token_bits = 0;
      token_acc = '0;
      copy_offset = '0;
   endfunction

   function automatic void store_symbol(input logic [SYM_BITS-1:0] sym);
      window_copy[window_wpos] = sym;
      window_wpos = window_wpos + 1'b1;
      word_symbols.push_back(sym);
   endfunction

   // Decodes one accepted code word and queues the symbols that it completes.
   function automatic void decode_word(input logic [15:0] w, input logic fin);
      logic                b_val;
      int                  need;
      int                  total;
      logic [OFF_BITS-1:0] rd_pos;
      decoded_symbol_type  entry;
      word_symbols.delete();
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         b_val = w[b];
         if (token_phase_m == PH_FLAG) begin
            if (b_val)
               token_phase_m = PH_LIT;
            else
               token_phase_m = PH_OFF;
            token_bits = 0;
            token_acc = '0;
         end else begin
            token_acc = {token_acc[14:0], b_val};
            token_bits++;
            if (token_phase_m == PH_LIT)
               need = SYM_BITS;
            else if (token_phase_m == PH_OFF)
               need = OFF_BITS;
            else
               need = LEN_BITS;
            if (token_bits == need) begin
               case (token_phase_m)
                  PH_LIT: begin
                     store_symbol(token_acc);
                     token_phase_m = PH_FLAG;
                  end
                  PH_OFF: begin
                     copy_offset = token_acc[OFF_BITS-1:0];
                     token_phase_m = PH_LEN;
                  end
                  default: begin
                     // Read and write alternate, so a copy can see its own output.
                     total = int'(token_acc) + 2;
                     rd_pos = copy_offset;
                     for (int k = 0; k < total; k++) begin
                        store_symbol(window_copy[rd_pos]);
                        rd_pos = rd_pos + 1'b1;
                     end
                     token_phase_m = PH_FLAG;
                  end
               endcase
               token_bits = 0;
               token_acc = '0;
            end
         end
      end
      if (fin) begin
         token_phase_m = PH_FLAG;
         token_bits = 0;
         token_acc = '0;
      end
      foreach (word_symbols[i]) begin
         entry.symbol = word_symbols[i];
         entry.last_of_run = (i == word_symbols.size() - 1);
         pending_symbols.push_back(entry);
      end
   endfunction

   function automatic void plan_field(input int unsigned value, input int width);
      for (int i = width - 1; i >= 0; i--)
         stream_bits.push_back(value[i]);
   endfunction

   function automatic void plan_literal(input logic [SYM_BITS-1:0] sym);
      stream_bits.push_back(1'b1);
      plan_field(32'(sym), SYM_BITS);
      plan_pos = plan_pos + 1'b1;
      literal_tokens++;
   endfunction

   function automatic void plan_copy(input logic [OFF_BITS-1:0] offset,
                                     input logic [LEN_BITS-1:0] len);
      stream_bits.push_back(1'b0);
      plan_field(32'(offset), OFF_BITS);
      plan_field(32'(len), LEN_BITS);
      plan_pos = plan_pos + OFF_BITS'(len) + OFF_BITS'(2);
      copy_tokens++;
   endfunction

   // Half of the copies reach back a short way, often overlapping their own output.
   function automatic void plan_random_token();
      int                  pick;
      logic [SYM_BITS-1:0] sym;
      pick = $urandom_range(99);
      if (pick < 40) begin
         case ($urandom_range(3))
            0: sym = '0;
            1: sym = '1;
            default: sym = SYM_BITS'($urandom);
         endcase
         plan_literal(sym);
      end else if (pick < 70) begin
         plan_copy(plan_pos - OFF_BITS'($urandom_range(1, 18)), LEN_BITS'($urandom_range(15)));
      end else if (pick < 85) begin
         plan_copy(plan_pos - OFF_BITS'($urandom_range(19, 400)), LEN_BITS'($urandom_range(15)));
      end else begin
         plan_copy(OFF_BITS'($urandom_range(WIN_DEPTH - 1)), LEN_BITS'($urandom_range(15)));
      end
   endfunction

   task automatic send_word(input logic [15:0] w, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      decode_word(w, fin);
      words_sent++;
   endtask

   // Pads the planned bits to whole words with random bits, which are too few
   // to complete a token, and sends them with the last word marked final. A
   // truncated stream is cut short at a random word, which is marked final.
   task automatic send_stream(input bit truncate);
      int          n_words;
      int          cut;
      logic [15:0] w;
      while (stream_bits.size() % WORD_BITS != 0)
         stream_bits.push_back(1'($urandom_range(1)));
      n_words = stream_bits.size() / WORD_BITS;
      cut = truncate ? $urandom_range(n_words - 1) : n_words - 1;
      for (int k = 0; k <= cut; k++) begin
         for (int i = 0; i < WORD_BITS; i++)
            w = {w[14:0], stream_bits.pop_front()};
         send_word(w, k == cut);
      end
      stream_bits.delete();
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_symbols.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_literal_extremes();
      plan_pos = window_wpos;
      plan_literal('1);
      plan_literal('0);
      plan_literal(16'h8000);
      plan_literal(16'h0001);
      send_stream(1'b0);
      drain_results();
   endtask

   task automatic test_window_copies();
      plan_pos = window_wpos;
      plan_copy('1, '1);               // longest copy, read wraps past the top
      plan_copy('0, '0);               // shortest copy from the bottom
      plan_copy(plan_pos - 1'b1, '1);  // repeats the last symbol
      plan_copy(11'd2040, '1);
      plan_literal(16'h5A5A);
      plan_copy(plan_pos - 2'd3, '1);  // overlapping three-symbol pattern
      send_stream(1'b0);
      drain_results();
   endtask

   task automatic test_final_word_drop();
      // A literal cut short by the final mark is dropped.
      send_word(16'hFFFF, 1'b1);
      // A fresh token starts after the final mark: a two-symbol copy from zero.
      send_word(16'h0000, 1'b1);
      // A literal that completes no symbol in its first word.
      send_word(16'hFFFF, 1'b0);
      // Completes the literal and leaves a copy waiting for its length.
      send_word(16'h0000, 1'b0);
      // Completes that copy, then drops a copy token still short of its length.
      send_word(16'h0000, 1'b1);
      drain_results();
   endtask

   task automatic test_random_stream(input int idle_pct, input int stall, input int n_words);
      int start_count;
      int n_noise;
      start_count = words_sent;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      while (words_sent - start_count < n_words) begin
         if ($urandom_range(99) < 80) begin
            plan_pos = window_wpos;
            repeat ($urandom_range(1, 6))
               plan_random_token();
            send_stream($urandom_range(99) < 15);
         end else begin
            // Noise words always end on a final word so that the next stream
            // starts on a token boundary.
            n_noise = $urandom_range(1, 3);
            for (int i = 0; i < n_noise; i++)
               send_word(16'($urandom), (i == n_noise - 1) ? 1'b1 : 1'($urandom_range(1)));
         end
      end
      drain_results();
   endtask

   task automatic test_output_hold_off();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 400;
      plan_pos = window_wpos;
      repeat (10)
         plan_random_token();
      send_stream(1'b0);
      // The sender now waits until every symbol has drained before going on.
      drain_results();
      plan_pos = window_wpos;
      repeat (4)
         plan_random_token();
      send_stream(1'b0);
      drain_results();
   endtask

   initial begin
      #5ms;
      $display("lzss_word_decoder_unit regression: fail");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      clear_decoder_copy();
      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      test_literal_extremes();
      test_window_copies();
      test_final_word_drop();
      test_random_stream(0, 0, 20);
      test_random_stream(79, 0, 20);
      test_random_stream(0, 79, 20);
      test_random_stream(37, 37, 20);
      test_output_hold_off();

      repeat (120)
         @(posedge clock);
      $display("Sent %0d code words; checked %0d symbols from %0d literal and %0d copy tokens.",
               words_sent, symbols_checked, literal_tokens, copy_tokens);
      $display("Streams ran with and without idling on each side, plus a long output hold-off.");
      if (mismatch_count == 0) begin
         $display("lzss_word_decoder_unit regression: pass");
      end else begin
         $display("lzss_word_decoder_unit regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lzwd_pkg.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_datapath.sv
rtl/lzwd_ctrl_check_order.sv
rtl/lzss_word_decoder_unit.sv
bench/lzss_word_decoder_unit_test.sv
